[design/prim_mst_dense_assert.svh]
// ----------------------------------------------------------------------------
// prim_mst_dense assertion macros
// Shared forms for the concurrent checks of the spanning tree block.
// ----------------------------------------------------------------------------
`ifndef PRIM_MST_DENSE_ASSERT_SVH
`define PRIM_MST_DENSE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prim_mst_dense check failed");

// The consequent must hold in the cycle after the antecedent.
`define PMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prim_mst_dense check failed");

`endif

[design/pmd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_pkg
// Field widths, opcodes, controller states and the command and status
// bundles shared by the spanning tree controller and datapath.
// ----------------------------------------------------------------------------
package pmd_pkg;

    localparam int OPCODE_W  = 2;
    localparam int NODE_W    = 7;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_W     = 7;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_SOLVE = 2'd2
    } opcode_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE_RD,
        ST_EDGE_CMP,
        ST_EDGE_WR2,
        ST_SWEEP,
        ST_DRAIN,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic clr_wr;
        logic edge_rd;
        logic wr_ab;
        logic wr_ba;
        logic solve_start;
        logic sweep_rd;
        logic round_next;
        logic emit_start;
        logic emit_rd;
        logic emit_next;
    } cmd_t;

    typedef struct packed {
        opcode_t opcode;
        logic    ep_ok;
        logic    edge_better;
        logic    clr_done;
        logic    cnt_last;
        logic    round_last;
        logic    found;
        logic    one_node;
    } sts_t;

endpackage

[design/pmd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_ctrl
// Sequencer for matrix clearing, edge insertion, Prim rounds and emission.
// ----------------------------------------------------------------------------
module pmd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  pmd_pkg::sts_t sts,
    output pmd_pkg::cmd_t cmd
);
    import pmd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    case (sts.opcode)
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_ADD:
                        begin
                            if (sts.ep_ok)
                            begin
                                state_next = ST_EDGE_RD;
                            end
                        end
                        OP_SOLVE:
                        begin
                            cmd.solve_start = 1'b1;
                            if (!sts.one_node)
                            begin
                                state_next = ST_SWEEP;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EDGE_RD:
            begin
                cmd.edge_rd = 1'b1;
                state_next  = ST_EDGE_CMP;
            end
            ST_EDGE_CMP:
            begin
                if (sts.edge_better)
                begin
                    cmd.wr_ab  = 1'b1;
                    state_next = ST_EDGE_WR2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EDGE_WR2:
            begin
                cmd.wr_ba  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.round_last || !sts.found)
                begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_EMIT_RD;
                end
                else
                begin
                    cmd.round_next = 1'b1;
                    state_next     = ST_SWEEP;
                end
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_OUT;
            end
            ST_EMIT_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (sts.cnt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.emit_next = 1'b1;
                        state_next    = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

[design/pmd_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_dpath
// Weight memory, per-node key store, round counters and the relaxation
// pipeline with its running minimum search.
// ----------------------------------------------------------------------------
module pmd_dpath #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [pmd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [pmd_pkg::OPCODE_W-1:0]   s_tuser,
    output logic [pmd_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pmd_pkg::CFG_W-1:0]      cfg_data,
    input  pmd_pkg::cmd_t                  cmd,
    output pmd_pkg::sts_t                  sts
);
    import pmd_pkg::*;

    localparam int NB       = $clog2(MAX_NODES);
    localparam int NW       = $clog2(MAX_NODES + 1);
    localparam int WB       = WEIGHT_BITS;
    localparam int MX_DEPTH = 1 << (2 * NB);
    localparam int PAD_W    = M_TDATA_W - 2 * NODE_W;

    // Input unpacking and endpoint checks.
    logic [NODE_W-1:0]   in_a;
    logic [NODE_W-1:0]   in_b;
    logic [WEIGHT_W-1:0] in_w_raw;
    logic [31:0]         a_wide;
    logic [31:0]         b_wide;
    logic [31:0]         w_wide;
    logic [31:0]         a_m1;
    logic [31:0]         b_m1;
    logic                a_ok;
    logic                b_ok;

    assign in_a     = s_tdata[NODE_W-1:0];
    assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
    assign in_w_raw = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign a_wide   = 32'(in_a);
    assign b_wide   = 32'(in_b);
    assign w_wide   = 32'(in_w_raw);
    assign a_m1     = a_wide - 32'd1;
    assign b_m1     = b_wide - 32'd1;
    assign a_ok     = (in_a != '0) && (a_wide <= 32'(MAX_NODES));
    assign b_ok     = (in_b != '0) && (b_wide <= 32'(MAX_NODES));

    logic [NB-1:0]        a_reg;
    logic [NB-1:0]        b_reg;
    logic signed [WB-1:0] w_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg <= a_m1[NB-1:0];
            b_reg <= b_m1[NB-1:0];
            w_reg <= signed'(w_wide[WB-1:0]);
        end
    end

    // Node count register and its clamped value.
    logic [CFG_W-1:0] node_count_reg;
    logic [31:0]      nc_wide;
    logic [31:0]      n_wide;
    logic [NW-1:0]    n_eff;
    logic [NW-1:0]    n_m1;
    logic [NW-1:0]    n_m2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            node_count_reg <= cfg_data;
        end
    end

    assign nc_wide = 32'(node_count_reg);

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_wide = 32'd1;
        end
        else if (nc_wide > 32'(MAX_NODES))
        begin
            n_wide = 32'(MAX_NODES);
        end
        else
        begin
            n_wide = nc_wide;
        end
    end

    assign n_eff = n_wide[NW-1:0];
    assign n_m1  = n_eff - NW'(1);
    assign n_m2  = n_eff - NW'(2);

    // Control counters and search state.
    logic [2*NB-1:0]      clr_reg;
    logic [NB-1:0]        cnt_reg;
    logic [NB-1:0]        round_reg;
    logic                 first_reg;
    logic                 found_reg;
    logic                 pipe_vld_reg;
    logic [NB-1:0]        u_reg;
    logic [NB-1:0]        next_u_reg;
    logic [NB-1:0]        v_d_reg;
    logic signed [WB-1:0] min_reg;

    // Relaxation pipeline signals.
    logic [WB:0]          mx_rd_reg;
    logic                 mx_rd_ok;
    logic signed [WB-1:0] mx_rd_w;
    logic                 nd_rd_in_reg;
    logic                 nd_rd_ok_reg;
    logic signed [WB-1:0] nd_rd_key_reg;
    logic [NW-1:0]        nd_rd_par_reg;
    logic                 rd_in;
    logic                 rd_ok;
    logic [NW-1:0]        rd_par;
    logic                 is_u;
    logic                 relax;
    logic                 new_in;
    logic                 new_ok;
    logic signed [WB-1:0] new_key;
    logic [NW-1:0]        new_par;
    logic                 cand;

    assign mx_rd_ok = mx_rd_reg[WB];
    assign mx_rd_w  = signed'(mx_rd_reg[WB-1:0]);

    // The first round sees the key store as freshly cleared.
    assign rd_in   = first_reg ? 1'b0 : nd_rd_in_reg;
    assign rd_ok   = first_reg ? 1'b0 : nd_rd_ok_reg;
    assign rd_par  = first_reg ? '0 : nd_rd_par_reg;
    assign is_u    = (v_d_reg == u_reg);
    assign relax   = !is_u && !rd_in && mx_rd_ok && (!rd_ok || (mx_rd_w < nd_rd_key_reg));
    assign new_in  = rd_in || is_u;
    assign new_ok  = rd_ok || relax;
    assign new_key = relax ? mx_rd_w : nd_rd_key_reg;
    assign new_par = relax ? (NW'(u_reg) + NW'(1)) : rd_par;
    assign cand    = !new_in && new_ok && (!found_reg || (new_key < min_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            cnt_reg      <= '0;
            round_reg    <= '0;
            first_reg    <= 1'b0;
            found_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
        end
        else
        begin
            pipe_vld_reg <= cmd.sweep_rd;
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.solve_start || cmd.round_next)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.emit_start)
            begin
                cnt_reg <= NB'(1);
            end
            else if (cmd.sweep_rd || cmd.emit_next)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.solve_start)
            begin
                round_reg <= '0;
                first_reg <= 1'b1;
            end
            else if (cmd.round_next)
            begin
                round_reg <= round_reg + 1'b1;
                first_reg <= 1'b0;
            end
            if (cmd.solve_start || cmd.round_next)
            begin
                found_reg <= 1'b0;
            end
            else if (pipe_vld_reg && cand)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_d_reg <= cnt_reg;
        if (cmd.solve_start)
        begin
            u_reg <= '0;
        end
        else if (cmd.round_next)
        begin
            u_reg <= next_u_reg;
        end
        if (pipe_vld_reg && cand)
        begin
            min_reg    <= new_key;
            next_u_reg <= v_d_reg;
        end
    end

    // Weight memory: one entry per ordered node pair, valid flag on top.
    logic [WB:0]     mx_mem [MX_DEPTH];
    logic            mx_we;
    logic            mx_re;
    logic [2*NB-1:0] mx_waddr;
    logic [2*NB-1:0] mx_raddr;
    logic [WB:0]     mx_wdata;

    assign mx_we    = cmd.clr_wr || cmd.wr_ab || cmd.wr_ba;
    assign mx_re    = cmd.edge_rd || cmd.sweep_rd;
    assign mx_raddr = cmd.edge_rd ? {a_reg, b_reg} : {u_reg, cnt_reg};
    assign mx_wdata = cmd.clr_wr ? '0 : {1'b1, w_reg};

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            mx_waddr = clr_reg;
        end
        else if (cmd.wr_ab)
        begin
            mx_waddr = {a_reg, b_reg};
        end
        else
        begin
            mx_waddr = {b_reg, a_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mx_we)
        begin
            mx_mem[mx_waddr] <= mx_wdata;
        end
        if (mx_re)
        begin
            mx_rd_reg <= mx_mem[mx_raddr];
        end
    end

    // Per-node store: visited flag, key and parent.
    logic                 nd_in_mem  [MAX_NODES];
    logic                 nd_ok_mem  [MAX_NODES];
    logic signed [WB-1:0] nd_key_mem [MAX_NODES];
    logic [NW-1:0]        nd_par_mem [MAX_NODES];
    logic                 nd_re;

    assign nd_re = cmd.sweep_rd || cmd.emit_rd;

    always_ff @(posedge clk)
    begin
        if (pipe_vld_reg)
        begin
            nd_in_mem[v_d_reg]  <= new_in;
            nd_ok_mem[v_d_reg]  <= new_ok;
            nd_key_mem[v_d_reg] <= new_key;
            nd_par_mem[v_d_reg] <= new_par;
        end
        if (nd_re)
        begin
            nd_rd_in_reg  <= nd_in_mem[cnt_reg];
            nd_rd_ok_reg  <= nd_ok_mem[cnt_reg];
            nd_rd_key_reg <= nd_key_mem[cnt_reg];
            nd_rd_par_reg <= nd_par_mem[cnt_reg];
        end
    end

    // Result fields come straight from the held read data and the counter.
    logic [31:0] child_wide;
    logic [31:0] par_wide;

    assign child_wide = 32'(cnt_reg) + 32'd1;
    assign par_wide   = 32'(nd_rd_par_reg);
    assign m_tdata    = {PAD_W'(0), par_wide[NODE_W-1:0], child_wide[NODE_W-1:0]};
    assign m_tuser[0] = (nd_rd_par_reg != '0);
    assign m_tlast    = sts.cnt_last;

    // Status to the controller.
    assign sts.opcode      = opcode_t'(s_tuser);
    assign sts.ep_ok       = a_ok && b_ok;
    assign sts.edge_better = !mx_rd_ok || (w_reg < mx_rd_w);
    assign sts.clr_done    = &clr_reg;
    assign sts.cnt_last    = (NW'(cnt_reg) == n_m1);
    assign sts.round_last  = (NW'(round_reg) == n_m2);
    assign sts.found       = found_reg;
    assign sts.one_node    = (n_eff == NW'(1));

endmodule

[design/prim_mst_dense.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prim_mst_dense
// Minimum spanning tree over a dense weight matrix by Prim's algorithm.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    tuser: opcode; tdata: node_a, node_b,
//                                        edge_weight
//   m_*       out   m_tvalid/m_tready    tdata: child_node, parent_node;
//                                        tuser: has_parent; tlast: last
//   cfg_*     in    cfg_valid/cfg_ready  cfg_data: node_count
//
// After reset, and for every clear item, the weight memory is swept one entry
// a cycle over all 2**(2*ceil(log2(MAX_NODES))) entries, 4096 at the default size.
// An add edge item reads the stored weight, compares, then makes two symmetric
// writes; it is dropped when its endpoints are out of range, and ends after the
// compare when the stored weight is not larger.
// A solve item runs up to n - 1 Prim rounds, each a sweep of one row through the
// single read port of the weight memory, then a drain and a decide step; it then
// reads and sends each result in turn, holding on any output stall.
// The input is not ready while an item is in progress.
// ----------------------------------------------------------------------------
module prim_mst_dense #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, from bit 0: node_a[6:0], node_b[13:7], edge_weight[29:14],
    // zero fill [31:30].
    input  logic [pmd_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser, from bit 0: opcode[1:0].
    input  logic [pmd_pkg::OPCODE_W-1:0]  s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, from bit 0: child_node[6:0], parent_node[13:7], zero fill [15:14].
    output logic [pmd_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser, from bit 0: has_parent[0].
    output logic [0:0]                    m_tuser,
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pmd_pkg::CFG_W-1:0]     cfg_data
);
    import pmd_pkg::*;

    // The controller sequences every operation; the datapath owns all storage.
    // They talk only through the command and status bundles.
    cmd_t cmd;
    sts_t sts;

    pmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Each Prim round is one pass over the current node's row. The pass
    // relaxes every unvisited neighbor and, in the same pipeline, keeps the
    // running minimum that names the node of the next round, so selection
    // costs no extra pass.
    pmd_dpath #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[design/pmd_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmd_chk
// Port-level checks for the spanning tree block, bound to its top level.
// ----------------------------------------------------------------------------
`include "prim_mst_dense_assert.svh"

module pmd_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [6:0]  cfg_data
);

    // A stalled result stays offered with the same fields.
    `PMD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // The reached flag agrees with the reported parent.
    `PMD_ASSERT_SAME(a_parent_flag, clk, rst_n, m_tvalid,
        m_tuser[0] == (m_tdata[13:7] != 7'd0))

    // No new item is taken while results of a solve are still going out.
    `PMD_ASSERT_SAME(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)

    // The last result of a solve ends the burst.
    `PMD_ASSERT_NEXT(a_last_ends, clk, rst_n, m_tvalid && m_tready && m_tlast, !m_tvalid)

endmodule

bind prim_mst_dense pmd_chk u_pmd_chk (.*);
